### hdl/gpio_pkg.sv
package gpio_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_W         = 5;
    localparam int DEF_PIN_COUNT = 32;
    localparam int IN_TDATA_W    = 64;
    localparam int IN_TUSER_W    = 6;
    localparam int OUT_TDATA_W   = 104;
    localparam int GROUP_W       = 8;
    localparam int GROUPS        = DATA_W / GROUP_W;
    localparam int REG_COUNT     = 8;

    typedef enum logic [2:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_SET    = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_SAMPLE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        SEL_DOUT    = 3'd0,
        SEL_DIN     = 3'd1,
        SEL_DOE     = 3'd2,
        SEL_PIN2IRQ = 3'd3,
        SEL_IRQEN   = 3'd4,
        SEL_IRQLEV  = 3'd5,
        SEL_IRQPOL  = 3'd6,
        SEL_IRQSTAT = 3'd7
    } t_sel;

    // bus access decoded once, shared by every lane
    typedef struct packed {
        logic                 wr;
        logic                 set;
        logic                 clr;
        logic [REG_COUNT-1:0] hit;
    } t_bus_op;

    // one pin's share of every register but DIN
    typedef struct packed {
        logic dout;
        logic doe;
        logic route;
        logic en;
        logic lev;
        logic pol;
        logic stat;
    } t_lane_bits;

endpackage

### hdl/gpio_lane.sv
module gpio_lane
    import gpio_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_bus_op    i_op,
    input  logic       i_data,
    input  logic       i_pin,
    output t_lane_bits o_state,
    output t_lane_bits o_next
);

    t_lane_bits r_bits;
    t_lane_bits n_bits;
    logic       r_prev;
    logic       n_stat_bus;
    logic       edge_hit;
    logic       level_hit;

    function automatic logic apply(input logic old, input logic d, input logic hit,
                                   input t_bus_op op);
        logic res;
        res = old;
        if (hit) begin
            if (op.wr) begin
                res = d;
            end else if (op.set) begin
                res = old | d;
            end else if (op.clr) begin
                res = old & ~d;
            end
        end
        return res;
    endfunction

    always_comb begin
        n_bits.dout  = apply(r_bits.dout,  i_data, i_op.hit[SEL_DOUT],    i_op);
        n_bits.doe   = apply(r_bits.doe,   i_data, i_op.hit[SEL_DOE],     i_op);
        n_bits.route = apply(r_bits.route, i_data, i_op.hit[SEL_PIN2IRQ], i_op);
        n_bits.en    = apply(r_bits.en,    i_data, i_op.hit[SEL_IRQEN],   i_op);
        n_bits.lev   = apply(r_bits.lev,   i_data, i_op.hit[SEL_IRQLEV],  i_op);
        n_bits.pol   = apply(r_bits.pol,   i_data, i_op.hit[SEL_IRQPOL],  i_op);
        n_stat_bus   = apply(r_bits.stat,  i_data, i_op.hit[SEL_IRQSTAT], i_op);
        // detection sees the registers as just updated by the bus
        edge_hit  = ~n_bits.lev & (n_bits.pol ? (i_pin & ~r_prev) : (~i_pin & r_prev));
        level_hit = n_bits.lev & ~(i_pin ^ n_bits.pol);
        n_bits.stat = n_stat_bus | (n_bits.route & (edge_hit | level_hit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_prev <= 1'b0;
        end else if (i_en) begin
            r_bits <= n_bits;
            r_prev <= i_pin;
        end
    end

    assign o_state = r_bits;
    assign o_next  = n_bits;

endmodule

### hdl/gpio_merge.sv
module gpio_merge
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = DEF_PIN_COUNT
) (
    input  logic [PIN_COUNT-1:0] i_pend,
    output logic                 o_any,
    output logic [IDX_W-1:0]     o_index
);

    logic [DATA_W-1:0]  pend_ext;
    logic [GROUPS-1:0]  grp_any;
    logic [2:0]         grp_idx [GROUPS];

    assign pend_ext = DATA_W'(i_pend);

    // highest set bit inside each byte, then highest busy byte
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_any[g] = |pend_ext[g*GROUP_W +: GROUP_W];
            grp_idx[g] = '0;
            for (int b = 0; b < GROUP_W; b++) begin
                if (pend_ext[g*GROUP_W + b]) begin
                    grp_idx[g] = 3'(b);
                end
            end
        end
        o_any   = |grp_any;
        o_index = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (grp_any[g]) begin
                o_index = {2'(g), grp_idx[g]};
            end
        end
    end

endmodule

### hdl/gpio_port_with_interrupt_detect_unit.sv
// GPIO port of up to 32 pins with edge and level interrupt detection. Each slave
// transaction carries one bus access (read, write, set bits, clear bits or sample
// only) and a sample of the pins; the access is applied first, then every pin lane
// checks its edge condition against the sample of the previous transaction or its
// level condition against the current one; routed pins set their sticky status bit.
// One result follows each transaction: the read value, the output and drive-enable
// registers, whether an enabled interrupt is pending and the highest pending pin. Each
// pin has its own lane and a byte-wise priority encoder merges the lanes. One
// transaction is taken every clock unless the two-entry output buffer is full; the
// buffer holds each result and lets input flow on while a result waits to be taken.
module gpio_port_with_interrupt_detect_unit
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = DEF_PIN_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // write_data [31:0], pin_levels [63:32]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // kind [2:0], reg_select [5:3]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // read_data [31:0], pad_out [63:32], pad_drive_enable [95:64], irq_request [96],
    // highest_pending [101:97], any_pending [102], zero [103]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic                   accept;
    logic                   pop;
    t_kind                  kind;
    t_sel                   sel;
    logic [DATA_W-1:0]      wdata;
    logic [PIN_COUNT-1:0]   pins;
    t_bus_op                op;
    t_lane_bits             lane_st [PIN_COUNT];
    t_lane_bits             lane_nx [PIN_COUNT];
    logic [PIN_COUNT-1:0]   v_dout, v_doe, v_route, v_en, v_lev, v_pol, v_stat;
    logic [PIN_COUNT-1:0]   nx_dout, nx_doe, nx_pend;
    logic [PIN_COUNT-1:0]   rd_sel;
    logic                   any_pend;
    logic [IDX_W-1:0]       hi_idx;
    logic [OUT_TDATA_W-1:0] result;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;
    logic                   r_skid_valid, n_skid_valid;
    logic [OUT_TDATA_W-1:0] r_skid_data,  n_skid_data;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    assign kind  = t_kind'(i_s_tuser[2:0]);
    assign sel   = t_sel'(i_s_tuser[5:3]);
    assign wdata = i_s_tdata[DATA_W-1:0];
    assign pins  = i_s_tdata[DATA_W +: PIN_COUNT];

    always_comb begin
        op.wr  = (kind == KIND_WRITE);
        op.set = (kind == KIND_SET);
        op.clr = (kind == KIND_CLEAR);
        op.hit = REG_COUNT'(1) << sel;
    end

    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_lane
        gpio_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_op    (op),
            .i_data  (wdata[p]),
            .i_pin   (pins[p]),
            .o_state (lane_st[p]),
            .o_next  (lane_nx[p])
        );
    end

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            v_dout[p]  = lane_st[p].dout;
            v_doe[p]   = lane_st[p].doe;
            v_route[p] = lane_st[p].route;
            v_en[p]    = lane_st[p].en;
            v_lev[p]   = lane_st[p].lev;
            v_pol[p]   = lane_st[p].pol;
            v_stat[p]  = lane_st[p].stat;
            nx_dout[p] = lane_nx[p].dout;
            nx_doe[p]  = lane_nx[p].doe;
            nx_pend[p] = lane_nx[p].stat & lane_nx[p].en;
        end
    end

    gpio_merge #(
        .PIN_COUNT (PIN_COUNT)
    ) u_merge (
        .i_pend  (nx_pend),
        .o_any   (any_pend),
        .o_index (hi_idx)
    );

    // read returns the register as it stood before this transaction
    always_comb begin
        case (sel)
            SEL_DOUT:    rd_sel = v_dout;
            SEL_DIN:     rd_sel = pins;
            SEL_DOE:     rd_sel = v_doe;
            SEL_PIN2IRQ: rd_sel = v_route;
            SEL_IRQEN:   rd_sel = v_en;
            SEL_IRQLEV:  rd_sel = v_lev;
            SEL_IRQPOL:  rd_sel = v_pol;
            SEL_IRQSTAT: rd_sel = v_stat;
            default:     rd_sel = '0;
        endcase
        if (kind != KIND_READ) begin
            rd_sel = '0;
        end
    end

    assign result = {1'b0, any_pend, hi_idx, any_pend,
                     DATA_W'(nx_doe), DATA_W'(nx_dout), DATA_W'(rd_sel)};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out_data  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = result;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### hdl/gpio_checker.sv
module gpio_checker
    import gpio_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // interrupt line and pending flag come from the same merge
    a_irq_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[96] == i_m_tdata[102]))
        else $error("irq_request and any_pending disagree");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tdata[102]) |-> (i_m_tdata[101:97] == '0))
        else $error("highest_pending nonzero with nothing pending");

    // buffer must keep room: a stalled result blocks input only after a second one
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled while output empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind gpio_port_with_interrupt_detect_unit gpio_checker u_gpio_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
